// ===== rtl/core/tcpq_pkg.sv =====
package tcpq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;

    // "cgi-bin/" with the first byte in the low bits
    localparam logic [63:0] SCRIPT_PREFIX = 64'h2F6E_6962_2D69_6763;

    // action codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // policy codes, the unused code acts as arrival order
    localparam logic [1:0] POL_ARRIVAL      = 2'd0;
    localparam logic [1:0] POL_STATIC_FIRST = 2'd1;
    localparam logic [1:0] POL_SCRIPT_FIRST = 2'd2;

    typedef struct packed {
        logic        action;
        logic [7:0]  req_kind;
        logic [9:0]  conn;
        logic [63:0] path_head;
        logic [15:0] file_tag;
        logic [31:0] arrival_time;
        logic [31:0] serve_time;
    } req_t;

    typedef struct packed {
        logic        got_entry;
        logic        was_empty;
        logic        was_full;
        logic [7:0]  out_kind;
        logic [9:0]  out_conn;
        logic [15:0] out_tag;
        logic        out_script;
        logic [31:0] out_arrival;
        logic [31:0] out_serve;
        logic [4:0]  occupancy;
    } res_t;

    // one stored request, tag held beside it at its own width
    typedef struct packed {
        logic        script;
        logic [7:0]  kind;
        logic [9:0]  conn;
        logic [31:0] arrival;
        logic [31:0] serve;
    } entry_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== rtl/core/tcpq_cell.sv =====
module tcpq_cell #(
    parameter int TAG_BITS = tcpq_pkg::TAG_BITS_DEF
) (
    input  logic                  clk,
    input  tcpq_pkg::cell_ctl_t   ctl,
    input  tcpq_pkg::entry_t      new_entry,
    input  logic [TAG_BITS-1:0]   new_tag,
    input  tcpq_pkg::entry_t      next_entry,
    input  logic [TAG_BITS-1:0]   next_tag,
    output tcpq_pkg::entry_t      entry,
    output logic [TAG_BITS-1:0]   tag
);
    import tcpq_pkg::*;

    entry_t              entry_reg;
    entry_t              entry_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // load at the tail, or close the gap by taking the upper neighbor
    always_comb
    begin
        entry_next = entry_reg;
        tag_next   = tag_reg;
        if (ctl.load)
        begin
            entry_next = new_entry;
            tag_next   = new_tag;
        end
        else if (ctl.shift)
        begin
            entry_next = next_entry;
            tag_next   = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tag_reg   <= tag_next;
    end

    assign entry = entry_reg;
    assign tag   = tag_reg;

endmodule

// ===== rtl/core/tcpq_pick.sv =====
module tcpq_pick #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic [QUEUE_DEPTH-1:0] valid_mask,
    input  logic [QUEUE_DEPTH-1:0] script_mask,
    input  logic [1:0]             policy,
    output logic [QUEUE_DEPTH-1:0] sel_onehot,
    output logic [QUEUE_DEPTH-1:0] shift_mask
);
    import tcpq_pkg::*;

    logic                   want_script;
    logic                   use_class;
    logic [QUEUE_DEPTH-1:0] match_want;
    logic [QUEUE_DEPTH-1:0] match_other;
    logic [QUEUE_DEPTH-1:0] cand;
    logic [QUEUE_DEPTH-1:0] cand_neg;

    assign want_script = (policy == POL_SCRIPT_FIRST);
    assign use_class   = (policy == POL_STATIC_FIRST) || (policy == POL_SCRIPT_FIRST);

    assign match_want  = valid_mask & (want_script ? script_mask : ~script_mask);
    assign match_other = valid_mask & (want_script ? ~script_mask : script_mask);

    always_comb
    begin
        if (!use_class)
            cand = valid_mask;
        else if (|match_want)
            cand = match_want;
        else
            cand = match_other;
    end

    // the negation keeps the lowest set bit; the or sets all bits above it
    assign cand_neg   = ~cand + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};
    assign sel_onehot = cand & cand_neg;
    assign shift_mask = cand | cand_neg;

endmodule

// ===== rtl/core/two_class_priority_request_queue_unit.sv =====
// Two-class request queue. Holds up to QUEUE_DEPTH requests in a row of cells in
// enqueue order, cell 0 the oldest. A request whose first eight path bytes read
// "cgi-bin/" is a script. An enqueue writes the tail cell, or is answered with
// was_full when every cell is taken. A dequeue removes one request chosen by
// policy_mode (0 oldest overall, 1 oldest non-script first, 2 oldest script
// first, 3 as 0); the chosen cell and every cell above it take their upper neighbor in
// the same cycle, so the row stays packed. Each request gives exactly one result,
// with occupancy after the request (modulo 32). Throughput is one request per
// clock: the choice is a single carry chain across the row of cell flags, and the
// input stalls only while a finished result sits in the output register with
// out_stall high. out_valid rises in the cycle after acceptance. Cells hold
// no reset value; only cells below the count are ever read, so no clearing pass
// is needed after reset. policy_mode is written through the cfg port, always
// ready, and must only change while the queue is quiet.
module two_class_priority_request_queue_unit #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = tcpq_pkg::TAG_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tcpq_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output tcpq_pkg::res_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_data
);
    import tcpq_pkg::*;

    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = $bits(entry_t);

    // control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    policy_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          out_data_reg;
    res_t          out_data_next;

    // cell row
    entry_t              cell_q   [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_q    [QUEUE_DEPTH];
    entry_t              nxt_q    [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] nxt_tag  [QUEUE_DEPTH];
    cell_ctl_t           cell_ctl [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] valid_mask;
    logic [QUEUE_DEPTH-1:0] tail_mask;
    logic [QUEUE_DEPTH-1:0] script_mask;
    logic [QUEUE_DEPTH-1:0] sel_onehot;
    logic [QUEUE_DEPTH-1:0] shift_mask;

    logic                accept;
    logic                is_enq;
    logic                full;
    logic                empty;
    logic                do_enq;
    logic                do_deq;
    entry_t              new_entry;
    logic [TAG_BITS-1:0] new_tag;
    logic [ENTRY_W-1:0]  pick_bits;
    logic [TAG_BITS-1:0] pick_tag;
    entry_t              pick_entry;

    // handshakes
    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_enq = (in_data.action == ACT_ENQUEUE);
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = accept && is_enq && !full;
    assign do_deq = accept && !is_enq && !empty;

    // incoming request in stored form, class decided here once
    always_comb
    begin
        new_entry.script  = (in_data.path_head == SCRIPT_PREFIX);
        new_entry.kind    = in_data.req_kind;
        new_entry.conn    = in_data.conn;
        new_entry.arrival = in_data.arrival_time;
        new_entry.serve   = in_data.serve_time;
        new_tag           = TAG_BITS'(in_data.file_tag);
    end

    // the row: each cell sees the new request and its upper neighbor
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign valid_mask[i]  = (CW'(i) < count_reg);
        assign tail_mask[i]   = (CW'(i) == count_reg);
        assign script_mask[i] = cell_q[i].script;

        assign cell_ctl[i].load  = do_enq && tail_mask[i];
        assign cell_ctl[i].shift = do_deq && shift_mask[i] && valid_mask[i];

        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign nxt_q[i]   = cell_q[i];
            assign nxt_tag[i] = tag_q[i];
        end
        else
        begin : g_mid
            assign nxt_q[i]   = cell_q[i + 1];
            assign nxt_tag[i] = tag_q[i + 1];
        end

        tcpq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .new_entry  (new_entry),
            .new_tag    (new_tag),
            .next_entry (nxt_q[i]),
            .next_tag   (nxt_tag[i]),
            .entry      (cell_q[i]),
            .tag        (tag_q[i])
        );
    end

    // policy select: one-hot of the request leaving, and cells at or above it
    tcpq_pick #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_pick (
        .valid_mask  (valid_mask),
        .script_mask (script_mask),
        .policy      (policy_reg),
        .sel_onehot  (sel_onehot),
        .shift_mask  (shift_mask)
    );

    // and-or read of the chosen cell
    always_comb
    begin
        pick_bits = '0;
        pick_tag  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            pick_bits = pick_bits | (cell_q[i] & {ENTRY_W{sel_onehot[i]}});
            pick_tag  = pick_tag | (tag_q[i] & {TAG_BITS{sel_onehot[i]}});
        end
        pick_entry = entry_t'(pick_bits);
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
            count_next = count_reg + CW'(1);
        else if (do_deq)
            count_next = count_reg - CW'(1);
    end

    // result of the current request
    always_comb
    begin
        out_data_next = '0;
        if (is_enq)
        begin
            out_data_next.was_full = full;
        end
        else if (empty)
        begin
            out_data_next.was_empty = 1'b1;
        end
        else
        begin
            out_data_next.got_entry   = 1'b1;
            out_data_next.out_kind    = pick_entry.kind;
            out_data_next.out_conn    = pick_entry.conn;
            out_data_next.out_tag     = 16'(pick_tag);
            out_data_next.out_script  = pick_entry.script;
            out_data_next.out_arrival = pick_entry.arrival;
            out_data_next.out_serve   = pick_entry.serve;
        end
        out_data_next.occupancy = 5'(count_next);
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            policy_reg    <= POL_ARRIVAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                policy_reg <= cfg_data;
        end
    end

    // result payload, loaded only when a request is taken
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    // a dequeue from a non-empty queue picks exactly one cell
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        do_deq |-> $onehot(sel_onehot))
        else $error("dequeue did not select exactly one cell");

    // a rejected enqueue leaves the count alone and reports full
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_enq && full |=> out_valid_reg && out_data_reg.was_full
            && $stable(count_reg))
        else $error("rejected enqueue changed the queue or was not flagged");

    // a successful dequeue lowers the count by one and reports the entry
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_deq |=> count_reg == $past(count_reg) - CW'(1) && out_data_reg.got_entry)
        else $error("dequeue count update mismatch");

endmodule

// ===== sim/two_class_priority_request_queue_unit_test.sv =====
`timescale 1ns / 1ps

module two_class_priority_request_queue_unit_test;

    import tcpq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // the policy code with no mode of its own
    localparam logic [1:0] POL_RESERVED = 2'd3;

    // one held request as the tracker sees it
    typedef struct {
        logic        script;
        logic [7:0]  kind;
        logic [9:0]  conn;
        logic [15:0] tag;
        logic [31:0] arrival;
        logic [31:0] serve;
    } held_request_t;

    // mirrors the queue contents and holds the results still owed by the block
    class request_queue_tracker;
        held_request_t held[$];
        res_t          owed_results[$];
        logic [1:0]    policy;
        int            errors;
        int            checked;

        function new();
            policy  = POL_ARRIVAL;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // oldest held request of the given class, -1 when there is none
        function int oldest_of_class(logic want_script);
            for (int i = 0; i < held.size(); i++) begin
                if (held[i].script == want_script)
                    return i;
            end
            return -1;
        endfunction

        function res_t serve_request(req_t r);
            res_t          res;
            held_request_t h;
            int            pick;
            logic          favor_script;
            res = '0;
            if (r.action == ACT_ENQUEUE) begin
                if (held.size() >= DEPTH) begin
                    res.was_full = 1'b1;
                end
                else begin
                    h.script  = (r.path_head == SCRIPT_PREFIX);
                    h.kind    = r.req_kind;
                    h.conn    = r.conn;
                    h.tag     = r.file_tag;
                    h.arrival = r.arrival_time;
                    h.serve   = r.serve_time;
                    held.push_back(h);
                end
            end
            else if (held.size() == 0) begin
                res.was_empty = 1'b1;
            end
            else begin
                pick = 0;
                if (policy == POL_STATIC_FIRST || policy == POL_SCRIPT_FIRST) begin
                    favor_script = (policy == POL_SCRIPT_FIRST);
                    pick = oldest_of_class(favor_script);
                    if (pick < 0)
                        pick = oldest_of_class(!favor_script);
                    if (pick < 0)
                        pick = 0;
                end
                h = held[pick];
                held.delete(pick);
                res.got_entry   = 1'b1;
                res.out_kind    = h.kind;
                res.out_conn    = h.conn;
                res.out_tag     = h.tag;
                res.out_script  = h.script;
                res.out_arrival = h.arrival;
                res.out_serve   = h.serve;
            end
            res.occupancy = 5'(held.size());
            return res;
        endfunction

        function void note_request(req_t r);
            owed_results.push_back(serve_request(r));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 50)
                $display("%0t: result %0d %s got %0h want %0h",
                         $time, checked, what, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(got.occupancy), 64'd0);
                return;
            end
            want = owed_results.pop_front();
            if (got.got_entry !== want.got_entry)
                report_mismatch("got_entry", 64'(got.got_entry), 64'(want.got_entry));
            if (got.was_empty !== want.was_empty)
                report_mismatch("was_empty", 64'(got.was_empty), 64'(want.was_empty));
            if (got.was_full !== want.was_full)
                report_mismatch("was_full", 64'(got.was_full), 64'(want.was_full));
            if (got.out_kind !== want.out_kind)
                report_mismatch("out_kind", 64'(got.out_kind), 64'(want.out_kind));
            if (got.out_conn !== want.out_conn)
                report_mismatch("out_conn", 64'(got.out_conn), 64'(want.out_conn));
            if (got.out_tag !== want.out_tag)
                report_mismatch("out_tag", 64'(got.out_tag), 64'(want.out_tag));
            if (got.out_script !== want.out_script)
                report_mismatch("out_script", 64'(got.out_script), 64'(want.out_script));
            if (got.out_arrival !== want.out_arrival)
                report_mismatch("out_arrival", 64'(got.out_arrival),
                                64'(want.out_arrival));
            if (got.out_serve !== want.out_serve)
                report_mismatch("out_serve", 64'(got.out_serve), 64'(want.out_serve));
            if (got.occupancy !== want.occupancy)
                report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
            checked++;
        endtask
    endclass

    // clock and stimulus side of the block
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    req_t       in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    res_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = 2'd0;

    // idle rates in percent, changed by the main sequence between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    request_queue_tracker tracker = new();

    two_class_priority_request_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls at random, one decision per edge
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // every result taken at an edge is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // offer one request, with random idle cycles ahead of it, and wait for it to be taken
    task send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(r);
    endtask

    // hold off the sender until every owed result has come back
    task drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
        @(posedge clk);
    endtask

    // policy changes only with the queue quiet
    task write_policy(logic [1:0] mode);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.policy = mode;
    endtask

    function automatic req_t make_request(logic act, logic [7:0] kind, logic [9:0] conn,
                                          logic [63:0] path, logic [15:0] tag,
                                          logic [31:0] arrival, logic [31:0] serve);
        req_t r;
        r.action       = act;
        r.req_kind     = kind;
        r.conn         = conn;
        r.path_head    = path;
        r.file_tag     = tag;
        r.arrival_time = arrival;
        r.serve_time   = serve;
        return r;
    endfunction

    // half the paths are the exact script prefix, some miss it by one bit
    function automatic req_t random_request(int enq_pct);
        req_t        r;
        int          sel;
        logic [63:0] path;
        sel = $urandom_range(9);
        if (sel < 5)
            path = SCRIPT_PREFIX;
        else if (sel < 6)
            path = SCRIPT_PREFIX ^ (64'd1 << $urandom_range(63));
        else
            path = {$urandom, $urandom};
        r = make_request(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE,
                         8'($urandom), 10'($urandom), path, 16'($urandom),
                         $urandom, $urandom);
        return r;
    endfunction

    // policy for each random phase, the unused code among them
    logic [1:0] phase_policy [8] = '{POL_SCRIPT_FIRST, POL_STATIC_FIRST, POL_RESERVED,
                                     POL_ARRIVAL, POL_SCRIPT_FIRST, POL_STATIC_FIRST,
                                     POL_ARRIVAL, POL_SCRIPT_FIRST};

    initial
    begin
        int          enq_pct;
        logic [63:0] path;
        // reset held from the start, released on an edge
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, arrival order after reset
        // dequeue on an empty queue
        send_request(make_request(ACT_DEQUEUE, '1, '1, '1, '1, '1, '1));
        // fill every slot: extremes first, then alternating classes
        send_request(make_request(ACT_ENQUEUE, '1, '1, '1, '1, '1, '1));
        send_request(make_request(ACT_ENQUEUE, '0, '0, SCRIPT_PREFIX, '0, '0, '0));
        send_request(make_request(ACT_ENQUEUE, '0, '0, '0, '0, '0, '0));
        // prefix with its top bit flipped is not a script
        send_request(make_request(ACT_ENQUEUE, 8'h5a, 10'h2a5, SCRIPT_PREFIX ^ 64'h1 << 63,
                                  16'ha5a5, 32'h1234_5678, 32'h8765_4321));
        for (int i = 4; i < DEPTH; i++) begin
            path = (i % 2 == 0) ? SCRIPT_PREFIX : {$urandom, $urandom};
            send_request(make_request(ACT_ENQUEUE, 8'(i * 17), 10'(i * 61), path,
                                      16'(i * 4099), 32'(i * 32'h0101_0101),
                                      ~32'(i * 32'h0101_0101)));
        end
        // full queue turns the request away
        send_request(make_request(ACT_ENQUEUE, '1, '1, SCRIPT_PREFIX, '1, '1, '1));
        repeat (3) send_request(make_request(ACT_DEQUEUE, '0, '0, '0, '0, '0, '0));
        write_policy(POL_SCRIPT_FIRST);
        repeat (2) send_request(make_request(ACT_DEQUEUE, '1, '1, '1, '1, '1, '1));
        write_policy(POL_STATIC_FIRST);
        repeat (2) send_request(make_request(ACT_DEQUEUE, '0, '0, '0, '0, '0, '0));

        // random part in eight phases of 50 requests
        for (int ph = 0; ph < 8; ph++) begin
            write_policy(phase_policy[ph]);
            // slow receiver first, then slow sender, then full speed
            if (ph < 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 73;
            end
            else if (ph < 6) begin
                send_idle_pct = 73;
                recv_idle_pct = 20;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            enq_pct = 50;
            for (int n = 0; n < 50; n++) begin
                // bursts that lean toward filling or emptying the queue
                if (n % 10 == 0)
                    enq_pct = ($urandom_range(2) == 0) ? 85 :
                              ($urandom_range(1) == 0) ? 50 : 15;
                // one pause mid-phase until everything owed has come back
                if (ph == 4 && n == 25)
                    drain_results();
                send_request(random_request(enq_pct));
            end
        end

        // wind down and give stray results a chance to show up
        drain_results();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
